// ===== hw/rtl/trsc_pkg.sv =====
// Shared types, constants and helper functions for the two-rotor substitution cipher.
`timescale 1ns / 1ps
`default_nettype none

package trsc_pkg;

  localparam int ROTOR_SIZE = 28;
  localparam int POS_W      = 5;

  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t ROTOR_SIZE_P = 5'd28;
  localparam pos_t LAST_POS     = 5'd27;
  localparam pos_t SYM_SPACE    = 5'd26;
  localparam pos_t SYM_PERIOD   = 5'd27;

  // func codes
  localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [1:0] FUNC_ENCRYPT = 2'd2;
  localparam logic [1:0] FUNC_DECRYPT = 2'd3;

  // config register indexes
  localparam logic CFG_ROTOR_A_START = 1'b0;
  localparam logic CFG_ROTOR_B_START = 1'b1;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_QUERY  = 8'h3F;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;

  typedef logic [2:0] upc_t;

  typedef enum logic [2:0] {
    OP_FETCH,
    OP_DISPATCH,
    OP_READ_SRC,
    OP_LATCH_PLACE,
    OP_SCAN,
    OP_SCAN_END,
    OP_EMIT,
    OP_LOAD
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_ACCEPT,
    COND_LOAD,
    COND_NOT_SYM,
    COND_SCAN_LAST,
    COND_OUT_FREE
  } cond_t;

  // one microcode word: datapath op, jump condition, hold-on-false, jump target
  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  hold;
    upc_t  target;
  } uword_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic accept;
    logic is_load;
    logic not_sym;
    logic scan_last;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic valid;
    pos_t sym;
  } sym_t;

  // (a + b) mod 28, both operands below 28
  function automatic pos_t mod_add(input pos_t a, input pos_t b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, ROTOR_SIZE_P}) begin
      s = s - {1'b0, ROTOR_SIZE_P};
    end
    return s[POS_W-1:0];
  endfunction

  // (a - b) mod 28, both operands below 28
  function automatic pos_t mod_sub(input pos_t a, input pos_t b);
    if (a >= b) begin
      return a - b;
    end
    return a + ROTOR_SIZE_P - b;
  endfunction

  // fold a 5-bit register value into 0..27
  function automatic pos_t mod_fold(input pos_t a);
    if (a >= ROTOR_SIZE_P) begin
      return a - ROTOR_SIZE_P;
    end
    return a;
  endfunction

  function automatic sym_t sym_of(input logic [7:0] c);
    sym_t r;
    r.valid = 1'b1;
    r.sym   = '0;
    if (c == CH_SPACE) begin
      r.sym = SYM_SPACE;
    end else if (c == CH_PERIOD) begin
      r.sym = SYM_PERIOD;
    end else if (c inside {[CH_UA:CH_UZ]}) begin
      r.sym = POS_W'(c - CH_UA);
    end else if (c inside {[CH_LA:CH_LZ]}) begin
      r.sym = POS_W'(c - CH_LA);
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [7:0] char_of(input pos_t s);
    if (s == SYM_SPACE) begin
      return CH_SPACE;
    end
    if (s == SYM_PERIOD) begin
      return CH_PERIOD;
    end
    return CH_UA + 8'(s);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/trsc_ifs.sv =====
// Valid/ready channel interfaces for the cipher input and result streams.
`timescale 1ns / 1ps
`default_nettype none

interface trsc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [4:0] rotor_index;
  logic [7:0] wiring_value;
  logic [7:0] char_in;

  modport source (output valid, func, rotor_index, wiring_value, char_in, input ready);
  modport sink   (input valid, func, rotor_index, wiring_value, char_in, output ready);
endinterface

interface trsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       no_match;

  modport source (output valid, char_out, no_match, input ready);
  modport sink   (input valid, char_out, no_match, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/trsc_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jump logic.
`timescale 1ns / 1ps
`default_nettype none

module trsc_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  trsc_pkg::status_t status,
  output trsc_pkg::op_t     op
);
  import trsc_pkg::*;

  upc_t   upc_r;
  upc_t   upc_nxt;
  uword_t uw;
  logic   cond_true;

  function automatic uword_t urom(input upc_t a);
    uword_t w;
    case (a)
      3'd0:    w = '{op: OP_FETCH,       cond: COND_ACCEPT,    hold: 1'b1, target: 3'd1};
      3'd1:    w = '{op: OP_DISPATCH,    cond: COND_LOAD,      hold: 1'b0, target: 3'd7};
      3'd2:    w = '{op: OP_READ_SRC,    cond: COND_NOT_SYM,   hold: 1'b0, target: 3'd6};
      3'd3:    w = '{op: OP_LATCH_PLACE, cond: COND_ALWAYS,    hold: 1'b0, target: 3'd4};
      3'd4:    w = '{op: OP_SCAN,        cond: COND_SCAN_LAST, hold: 1'b1, target: 3'd5};
      3'd5:    w = '{op: OP_SCAN_END,    cond: COND_ALWAYS,    hold: 1'b0, target: 3'd6};
      3'd6:    w = '{op: OP_EMIT,        cond: COND_OUT_FREE,  hold: 1'b1, target: 3'd0};
      3'd7:    w = '{op: OP_LOAD,        cond: COND_ALWAYS,    hold: 1'b0, target: 3'd0};
      default: w = '{op: OP_FETCH,       cond: COND_ALWAYS,    hold: 1'b0, target: 3'd0};
    endcase
    return w;
  endfunction

  always_comb begin
    uw = urom(upc_r);
    case (uw.cond)
      COND_ALWAYS:    cond_true = 1'b1;
      COND_ACCEPT:    cond_true = status.accept;
      COND_LOAD:      cond_true = status.is_load;
      COND_NOT_SYM:   cond_true = status.not_sym;
      COND_SCAN_LAST: cond_true = status.scan_last;
      COND_OUT_FREE:  cond_true = status.out_free;
      default:        cond_true = 1'b1;
    endcase
    if (cond_true) begin
      upc_nxt = uw.target;
    end else if (uw.hold) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = upc_r + 3'd1;
    end
  end

  assign op = uw.op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= '0;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/trsc_datapath.sv =====
// Rotor stores, turn arithmetic, match scan and result register.
`timescale 1ns / 1ps
`default_nettype none

module trsc_datapath #(
  parameter int VALUE_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  trsc_pkg::op_t     op,
  output trsc_pkg::status_t status,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [4:0]        cfg_wdata,
  trsc_in_if.sink           in_chan,
  trsc_out_if.source        out_chan
);
  import trsc_pkg::*;

  logic [VALUE_WIDTH-1:0] mem_a_r [ROTOR_SIZE];
  logic [VALUE_WIDTH-1:0] mem_b_r [ROTOR_SIZE];
  logic [VALUE_WIDTH-1:0] rd_a_r;
  logic [VALUE_WIDTH-1:0] rd_b_r;
  logic [VALUE_WIDTH-1:0] place_r;
  logic [VALUE_WIDTH-1:0] src_rd;
  logic [VALUE_WIDTH-1:0] scan_rd;
  logic [VALUE_WIDTH-1:0] wval;

  logic [1:0] func_r;
  pos_t       idx_r;
  logic [7:0] wiring_r;
  logic [7:0] char_r;

  pos_t a_start_r;
  pos_t b_start_r;
  pos_t step_r;
  pos_t step_nxt;
  pos_t ta_r;
  pos_t tb_r;
  pos_t j_r;
  pos_t hit_r;
  logic found_r;

  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_miss_r;

  sym_t sym;
  logic enc;
  logic newline;
  logic accept;
  logic out_free;
  pos_t addr_a;
  pos_t addr_b;
  pos_t cmp_idx;

  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign sym      = sym_of(char_r);
  assign enc      = (func_r == FUNC_ENCRYPT);
  assign newline  = (char_r == CH_NL);
  assign wval     = VALUE_WIDTH'(wiring_r);
  assign cmp_idx  = j_r - 5'd1;
  assign step_nxt = (step_r == LAST_POS) ? '0 : step_r + 5'd1;

  // source rotor is read at the symbol, the other rotor at the scan position
  assign addr_a = enc ? mod_sub(sym.sym, ta_r) : mod_sub(j_r, ta_r);
  assign addr_b = enc ? mod_add(j_r, tb_r) : mod_add(sym.sym, tb_r);
  assign src_rd  = enc ? rd_a_r : rd_b_r;
  assign scan_rd = enc ? rd_b_r : rd_a_r;

  assign in_chan.ready = (op == OP_FETCH);

  assign status.accept    = accept;
  assign status.is_load   = (func_r == FUNC_LOAD_A) || (func_r == FUNC_LOAD_B);
  assign status.not_sym   = !sym.valid;
  assign status.scan_last = (j_r == LAST_POS);
  assign status.out_free  = out_free;

  assign out_chan.valid    = out_valid_r;
  assign out_chan.char_out = out_char_r;
  assign out_chan.no_match = out_miss_r;

  // rotor stores
  always_ff @(posedge clk) begin
    if (op == OP_LOAD && idx_r < ROTOR_SIZE_P) begin
      if (func_r == FUNC_LOAD_A) begin
        mem_a_r[idx_r] <= wval;
      end else begin
        mem_b_r[idx_r] <= wval;
      end
    end
    if (addr_a < ROTOR_SIZE_P) begin
      rd_a_r <= mem_a_r[addr_a];
    end
    if (addr_b < ROTOR_SIZE_P) begin
      rd_b_r <= mem_b_r[addr_b];
    end
  end

  // item capture, turns and scan
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= in_chan.func;
      idx_r    <= in_chan.rotor_index;
      wiring_r <= in_chan.wiring_value;
      char_r   <= in_chan.char_in;
    end
    case (op)
      OP_DISPATCH: begin
        ta_r <= mod_add(mod_fold(a_start_r), step_r);
        tb_r <= mod_add(mod_fold(b_start_r), step_r);
        j_r  <= '0;
      end
      OP_LATCH_PLACE: begin
        place_r <= src_rd;
        found_r <= 1'b0;
        j_r     <= j_r + 5'd1;
      end
      OP_SCAN: begin
        if (scan_rd == place_r) begin
          found_r <= 1'b1;
          hit_r   <= cmp_idx;
        end
        j_r <= j_r + 5'd1;
      end
      OP_SCAN_END: begin
        if (scan_rd == place_r) begin
          found_r <= 1'b1;
          hit_r   <= cmp_idx;
        end
      end
      default: begin
      end
    endcase
    if (op == OP_EMIT && out_free) begin
      if (!sym.valid) begin
        out_char_r <= char_r;
        out_miss_r <= 1'b0;
      end else if (found_r) begin
        out_char_r <= char_of(hit_r);
        out_miss_r <= 1'b0;
      end else begin
        out_char_r <= CH_QUERY;
        out_miss_r <= 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
      a_start_r   <= '0;
      b_start_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROTOR_A_START: a_start_r <= cfg_wdata;
          CFG_ROTOR_B_START: b_start_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (op == OP_EMIT && out_free) begin
        out_valid_r <= 1'b1;
        if (!newline) begin
          step_r <= step_nxt;
        end
      end
      if (op == OP_LOAD && idx_r < ROTOR_SIZE_P) begin
        step_r <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/two_rotor_substitution_cipher.sv =====
// Top level of the two-rotor substitution cipher: sequencer plus datapath.
// A letter, space or period is processed by reading the source rotor, then scanning all 28
// positions of the other rotor through one read port; other bytes and newline skip the scan.
// A new item is accepted only after the previous one has finished (loads give no result);
// a waiting result stalls only the emit step.
// Reset (rst_n low, synchronous) clears the turn count, start registers and result valid.
`timescale 1ns / 1ps
`default_nettype none

module two_rotor_substitution_cipher #(
  parameter int VALUE_WIDTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_wdata,
  trsc_in_if.sink    in_chan,
  trsc_out_if.source out_chan
);
  import trsc_pkg::*;

  // sequencer drives one op per cycle; datapath reports flags for the jumps
  op_t     op;
  status_t status;

  trsc_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .op     (op)
  );

  // rotor stores are held unturned; turns are applied to the addresses
  trsc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

// ===== dv/trsc_checker.sv =====
// Scoreboard for the cipher: mirrors rotor state, predicts each result and compares it.
`timescale 1ns / 1ps

module trsc_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_wdata,
  trsc_in_if         in_mon,
  trsc_out_if        out_mon,
  output int         fail_count,
  output int         pending,
  output int         results_seen,
  output int         misses_seen
);
  import trsc_pkg::*;

  typedef struct packed {
    logic [7:0] char_out;
    logic       no_match;
  } cipher_char_t;

  cipher_char_t awaited_chars[$];

  // unturned wiring, as loaded
  logic [7:0] wiring_a [ROTOR_SIZE];
  logic [7:0] wiring_b [ROTOR_SIZE];
  logic [4:0] a_start_turns;
  logic [4:0] b_start_turns;
  int         chars_since_load;
  int         fail_tally;
  int         result_tally;
  int         miss_tally;

  assign fail_count   = fail_tally;
  assign results_seen = result_tally;
  assign misses_seen  = miss_tally;

  // -1 for bytes outside the alphabet
  function automatic int text_symbol(input logic [7:0] b);
    if (b >= CH_UA && b <= CH_UZ) begin
      return int'(b) - int'(CH_UA);
    end
    if (b >= CH_LA && b <= CH_LZ) begin
      return int'(b) - int'(CH_LA);
    end
    if (b == CH_SPACE) begin
      return int'(SYM_SPACE);
    end
    if (b == CH_PERIOD) begin
      return int'(SYM_PERIOD);
    end
    return -1;
  endfunction

  function automatic logic [7:0] symbol_text(input int s);
    case (s)
      int'(SYM_SPACE):  return CH_SPACE;
      int'(SYM_PERIOD): return CH_PERIOD;
      default:          return 8'(int'(CH_UA) + s);
    endcase
  endfunction

  // rotor A turned right, rotor B turned left
  function automatic logic [7:0] rotor_a_at(input int pos);
    int turn;
    turn = (int'(a_start_turns) % ROTOR_SIZE + chars_since_load) % ROTOR_SIZE;
    return wiring_a[(pos + ROTOR_SIZE - turn) % ROTOR_SIZE];
  endfunction

  function automatic logic [7:0] rotor_b_at(input int pos);
    int turn;
    turn = (int'(b_start_turns) % ROTOR_SIZE + chars_since_load) % ROTOR_SIZE;
    return wiring_b[(pos + turn) % ROTOR_SIZE];
  endfunction

  function automatic void predict_cipher_char(input logic [1:0] func, input logic [4:0] idx,
                                              input logic [7:0] wv, input logic [7:0] ch);
    cipher_char_t outcome;
    int           sym;
    int           hit;
    int           j;
    logic [7:0]   place;
    logic [7:0]   probe;
    if (func == FUNC_LOAD_A || func == FUNC_LOAD_B) begin
      if (idx < ROTOR_SIZE) begin
        if (func == FUNC_LOAD_A) begin
          wiring_a[idx] = wv;
        end else begin
          wiring_b[idx] = wv;
        end
        chars_since_load = 0;
      end
      return;
    end
    outcome.char_out = ch;
    outcome.no_match = 1'b0;
    if (ch != CH_NL) begin
      sym = text_symbol(ch);
      if (sym >= 0) begin
        place = (func == FUNC_ENCRYPT) ? rotor_a_at(sym) : rotor_b_at(sym);
        hit   = -1;
        for (j = 0; j < ROTOR_SIZE; j++) begin
          probe = (func == FUNC_ENCRYPT) ? rotor_b_at(j) : rotor_a_at(j);
          if (probe == place) begin
            hit = j;
          end
        end
        if (hit < 0) begin
          outcome.char_out = CH_QUERY;
          outcome.no_match = 1'b1;
        end else begin
          outcome.char_out = symbol_text(hit);
        end
      end
      chars_since_load = (chars_since_load + 1) % ROTOR_SIZE;
    end
    awaited_chars.push_back(outcome);
  endfunction

  always @(posedge clk) begin
    cipher_char_t want;
    if (!rst_n) begin
      a_start_turns    = '0;
      b_start_turns    = '0;
      chars_since_load = 0;
      awaited_chars.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ROTOR_A_START) begin
          a_start_turns = cfg_wdata;
        end else begin
          b_start_turns = cfg_wdata;
        end
      end
      // results first: an empty queue here is a stray result
      if (out_mon.valid && out_mon.ready) begin
        result_tally++;
        if (out_mon.no_match) begin
          miss_tally++;
        end
        if (awaited_chars.size() == 0) begin
          $error("unexpected result: char_out %h no_match %b",
                 out_mon.char_out, out_mon.no_match);
          fail_tally++;
        end else begin
          want = awaited_chars.pop_front();
          if (out_mon.char_out !== want.char_out) begin
            $error("char_out mismatch: expected %h, actual %h",
                   want.char_out, out_mon.char_out);
            fail_tally++;
          end
          if (out_mon.no_match !== want.no_match) begin
            $error("no_match mismatch: expected %b, actual %b",
                   want.no_match, out_mon.no_match);
            fail_tally++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_cipher_char(in_mon.func, in_mon.rotor_index, in_mon.wiring_value,
                            in_mon.char_in);
      end
    end
    pending <= awaited_chars.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the two-rotor cipher: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module tb_top;
  import trsc_pkg::*;

  // Longest quiet spell: a symbol scan plus short random stalls on
  // both sides and the settle pause before register writes; generous margin.
  localparam int QUIET_LIMIT     = 2000;
  // A trailing load may still be in flight after the last result, so wait
  // beyond the longest item before touching regs.
  localparam int SETTLE_CYCLES   = 40;
  localparam int RESET_CYCLES    = 6;
  localparam int PHASES          = 4;
  localparam int ITEMS_PER_PHASE = 24;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [4:0] cfg_wdata;
  logic       steady;        // both sides run flat out while high

  int fail_count;
  int pending;
  int results_seen;
  int misses_seen;
  int sent_count;
  int settings_done;
  int quiet_cycles;

  trsc_in_if  in_chan ();
  trsc_out_if out_chan ();

  two_rotor_substitution_cipher u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  trsc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .misses_seen  (misses_seen)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure: while steady is low, ready drops about 6 percent of the time.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= steady || ($urandom_range(0, 99) >= 6);
    end
  end

  // Watchdog: counts cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst_n && !(in_chan.valid && in_chan.ready) && !(out_chan.valid && out_chan.ready)) begin
      quiet_cycles++;
    end else begin
      quiet_cycles = 0;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One input transaction, with an occasional random gap ahead of it.
  // Returns just after the edge at which it was accepted; valid stays high.
  task automatic send_item(input logic [1:0] func, input logic [4:0] idx,
                           input logic [7:0] wv, input logic [7:0] ch);
    while (!steady && $urandom_range(0, 99) < 6) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.func         <= func;
    in_chan.rotor_index  <= idx;
    in_chan.wiring_value <= wv;
    in_chan.char_in      <= ch;
    @(posedge clk);
    while (!in_chan.ready) begin
      @(posedge clk);
    end
    sent_count++;
  endtask

  // Both start registers, back to back; only called with the block idle.
  task automatic set_turns(input logic [4:0] a_turns, input logic [4:0] b_turns);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROTOR_A_START;
    cfg_wdata <= a_turns;
    @(posedge clk);
    cfg_index <= CFG_ROTOR_B_START;
    cfg_wdata <= b_turns;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  // Drop valid, wait for every expected result, then let any trailing
  // load finish before the caller touches the registers.
  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Full rewiring of both rotors.
  //   0: same 28 distinct values on both rotors, shuffled - always a match
  //   1: values from a narrow range - repeats (last match wins) and misses
  //   2: full byte range - mostly misses
  task automatic load_rotors(input int fill);
    logic [7:0] vals_a [ROTOR_SIZE];
    logic [7:0] vals_b [ROTOR_SIZE];
    logic [7:0] swap;
    int         base;
    int         pick;
    int         k;
    base = $urandom_range(0, 255);
    for (k = 0; k < ROTOR_SIZE; k++) begin
      case (fill)
        0: begin
          vals_a[k] = 8'(9 * k + base);
          vals_b[k] = vals_a[k];
        end
        1: begin
          vals_a[k] = 8'($urandom_range(0, 40));
          vals_b[k] = 8'($urandom_range(0, 40));
        end
        default: begin
          vals_a[k] = 8'($urandom_range(0, 255));
          vals_b[k] = 8'($urandom_range(0, 255));
        end
      endcase
    end
    for (k = ROTOR_SIZE - 1; k > 0; k--) begin
      pick         = $urandom_range(0, k);
      swap         = vals_b[k];
      vals_b[k]    = vals_b[pick];
      vals_b[pick] = swap;
    end
    for (k = 0; k < ROTOR_SIZE; k++) begin
      send_item(FUNC_LOAD_A, 5'(k), vals_a[k], 8'($urandom));
    end
    for (k = 0; k < ROTOR_SIZE; k++) begin
      send_item(FUNC_LOAD_B, 5'(k), vals_b[k], 8'($urandom));
    end
  endtask

  initial begin
    logic [4:0] a_turns;
    logic [4:0] b_turns;
    logic [1:0] func;
    logic [7:0] ch;
    int         phase;
    int         roll;
    int         n;
    int         i;

    // block inputs known from time zero; result ready follows at the first edge
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_ROTOR_A_START;
    cfg_wdata            = '0;
    steady               = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.func         = FUNC_LOAD_A;
    in_chan.rotor_index  = '0;
    in_chan.wiring_value = '0;
    in_chan.char_in      = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // No turns; A wired as identity, B as its mirror, so after each load
    // the position of every symbol is known.
    set_turns(5'd0, 5'd0);
    for (i = 0; i < ROTOR_SIZE; i++) begin
      send_item(FUNC_LOAD_A, 5'(i), 8'(i), 8'($urandom));
    end
    for (i = 0; i < ROTOR_SIZE; i++) begin
      send_item(FUNC_LOAD_B, 5'(i), 8'(LAST_POS - 5'(i)), 8'($urandom));
    end

    // alphabet extremes in both cases, space and period, encrypting
    send_item(FUNC_ENCRYPT, '0, '0, "A");
    send_item(FUNC_ENCRYPT, '0, '0, "Z");
    send_item(FUNC_ENCRYPT, '0, '0, "a");
    send_item(FUNC_ENCRYPT, '0, '0, "z");
    send_item(FUNC_ENCRYPT, '0, '0, CH_SPACE);
    send_item(FUNC_ENCRYPT, '0, '0, CH_PERIOD);
    // newline passes through and holds the rotors
    send_item(FUNC_ENCRYPT, '0, '0, CH_NL);
    send_item(FUNC_DECRYPT, '0, '0, CH_NL);
    // other bytes pass through but still turn the rotors; then letters, period and space decrypted
    send_item(FUNC_ENCRYPT, '0, '0, CH_QUERY);
    send_item(FUNC_DECRYPT, '0, '0, 8'h00);
    send_item(FUNC_ENCRYPT, '0, '0, 8'hFF);
    send_item(FUNC_DECRYPT, '0, '0, 8'h80);
    send_item(FUNC_DECRYPT, '0, '0, "m");
    send_item(FUNC_DECRYPT, '0, '0, "Q");
    send_item(FUNC_DECRYPT, '0, '0, CH_PERIOD);
    send_item(FUNC_DECRYPT, '0, '0, CH_SPACE);
    // loads beyond the rotor are dropped and leave the turn count alone
    send_item(FUNC_LOAD_A, 5'd31, 8'hFF, 8'hFF);
    send_item(FUNC_ENCRYPT, '0, '0, "B");
    send_item(FUNC_LOAD_B, 5'd28, 8'h00, 8'h00);
    // A[5] gets a value B lacks: 'F' finds nothing
    send_item(FUNC_LOAD_A, 5'd5, 8'hFF, "x");
    send_item(FUNC_ENCRYPT, '0, '0, "F");
    // B[20] and B[25] both hold 7: 'H' must take the later one
    send_item(FUNC_LOAD_B, 5'd25, 8'd7, "y");
    send_item(FUNC_ENCRYPT, '0, '0, "H");
    // B[0] now matches A[5] on the way back
    send_item(FUNC_LOAD_B, 5'd0, 8'hFF, "w");
    send_item(FUNC_DECRYPT, '0, '0, "A");

    // ---- random part ----
    // Each phase: new turn settings at the extremes, a full rewiring,
    // then mostly text with the odd stray load mixed in.
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0:       begin a_turns = 5'd27; b_turns = 5'd27; end
        1:       begin a_turns = 5'd31; b_turns = 5'd0;  end
        2:       begin a_turns = 5'd0;  b_turns = 5'd31; end
        3:       begin a_turns = 5'd28; b_turns = 5'd29; end
        default: begin
          a_turns = 5'($urandom_range(0, 31));
          b_turns = 5'($urandom_range(0, 31));
        end
      endcase
      set_turns(a_turns, b_turns);
      // one long stretch with no idling on either channel
      steady <= (phase == 2);
      load_rotors(phase % 3);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(0, 99);
        func = $urandom_range(0, 1) ? FUNC_ENCRYPT : FUNC_DECRYPT;
        if (roll < 6) begin
          // rewire one entry mid-text: restarts the turn count
          send_item($urandom_range(0, 1) ? FUNC_LOAD_A : FUNC_LOAD_B,
                    5'($urandom_range(0, ROTOR_SIZE - 1)), 8'($urandom), 8'($urandom));
        end else if (roll < 9) begin
          send_item($urandom_range(0, 1) ? FUNC_LOAD_A : FUNC_LOAD_B,
                    5'($urandom_range(ROTOR_SIZE, 31)), 8'($urandom), 8'($urandom));
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 45) begin
            ch = 8'(int'(CH_UA) + $urandom_range(0, 25));
          end else if (roll < 70) begin
            ch = 8'(int'(CH_LA) + $urandom_range(0, 25));
          end else if (roll < 78) begin
            ch = $urandom_range(0, 1) ? CH_SPACE : CH_PERIOD;
          end else if (roll < 86) begin
            ch = CH_NL;
          end else begin
            ch = 8'($urandom_range(0, 255));
          end
          // load fields carry junk on text transactions
          send_item(func, 5'($urandom), 8'($urandom), ch);
        end
      end
    end
    steady <= 1'b0;

    settle();
    $display("Covered %0d input transactions under %0d turn settings and three wiring styles.",
             sent_count, settings_done);
    $display("Checked %0d results, %0d of them with no match.", results_seen, misses_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/trsc_pkg.sv
hw/rtl/trsc_ifs.sv
hw/rtl/trsc_seq.sv
hw/rtl/trsc_datapath.sv
hw/rtl/two_rotor_substitution_cipher.sv
dv/trsc_checker.sv
dv/tb_top.sv
